@@ hw/rtl/xsr_pkg.sv @@
// Shared types and constants for the xorshift128 range generator.
`timescale 1ns / 1ps

package xsr_pkg;

   localparam int WordW = 32;
   localparam int CntW  = $clog2(WordW);

   localparam logic [WordW-1:0] INIT_X = 32'd123456789;
   localparam logic [WordW-1:0] INIT_Y = 32'd362436069;
   localparam logic [WordW-1:0] INIT_Z = 32'd521288629;
   localparam logic [WordW-1:0] INIT_W = 32'd88675123;
   localparam logic [WordW-1:0] MASK31 = 32'h7fff_ffff;
   localparam logic [WordW-1:0] MASK23 = 32'h007f_ffff;

   localparam int SHIFT_A = 11;
   localparam int SHIFT_B = 19;
   localparam int SHIFT_C = 8;

   typedef enum logic [1:0] {
      CMD_NEXT   = 2'd0,
      CMD_RANGE  = 2'd1,
      CMD_FRAC   = 2'd2,
      CMD_RESEED = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_START,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic advance;
      logic reseed;
   } state_ctl_type;

endpackage

@@ hw/rtl/xsr_state.sv @@
// Generator state words with the xorshift128 advance and the reseed load.
`timescale 1ns / 1ps

module xsr_state (
   input  logic                        clock,
   input  logic                        reset,
   input  xsr_pkg::state_ctl_type      ctl,
   input  logic [xsr_pkg::WordW-1:0]   seed,
   output logic [xsr_pkg::WordW-1:0]   word_w
);
   import xsr_pkg::*;

   logic [WordW-1:0] x_ff, y_ff, z_ff, w_ff;
   logic [WordW-1:0] x_in, y_in, z_in, w_in;
   logic [WordW-1:0] t_word;
   logic [WordW-1:0] seed_word;

   assign t_word = x_ff ^ (x_ff << SHIFT_A);

   // A seed that is zero or has its sign bit set falls back to the default word.
   assign seed_word = ((seed == '0) || seed[WordW-1]) ? INIT_W : seed;

   always_comb begin
      priority if (ctl.reseed) begin
         x_in = INIT_X;
         y_in = INIT_Y;
         z_in = INIT_Z;
         w_in = seed_word;
      end else if (ctl.advance) begin
         x_in = y_ff;
         y_in = z_ff;
         z_in = w_ff;
         w_in = (w_ff ^ (w_ff >> SHIFT_B)) ^ (t_word ^ (t_word >> SHIFT_C));
      end else begin
         x_in = x_ff;
         y_in = y_ff;
         z_in = z_ff;
         w_in = w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= INIT_X;
         y_ff <= INIT_Y;
         z_ff <= INIT_Z;
         w_ff <= INIT_W;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         w_ff <= w_in;
      end
   end

   assign word_w = w_ff;

endmodule

@@ hw/rtl/xsr_div.sv @@
// Bit-serial restoring remainder unit: one dividend bit enters per cycle.
`timescale 1ns / 1ps

module xsr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [xsr_pkg::WordW-1:0]   dividend,
   input  logic [xsr_pkg::WordW-1:0]   divisor,
   output logic                        done,
   output logic [xsr_pkg::WordW-1:0]   remainder
);
   import xsr_pkg::*;

   logic [WordW-1:0] num_ff, num_in;
   logic [WordW-1:0] rem_ff, rem_in;
   logic [WordW-1:0] dsr_ff, dsr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WordW:0]   shifted;
   logic [WordW:0]   diff;

   // The dividend leaves the shift register MSB first into the partial remainder.
   assign shifted = {rem_ff, num_ff[WordW-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      priority if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[WordW-2:0], 1'b0};
         rem_in = diff[WordW] ? shifted[WordW-1:0] : diff[WordW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(WordW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/xorshift128_range_generator.sv @@
// Top level of the xorshift128 generator with range, fraction and reseed commands.
`timescale 1ns / 1ps

// The request channel (req_valid, req_stall, req_command, req_range_low,
// req_range_high) takes one command per beat; the block holds req_stall
// high once it has accepted a command until that command's result is
// registered. The response channel (rsp_valid, rsp_stall, rsp_value)
// returns one beat per command. The user must write the seed register
// through csr_wr_en/csr_wr_data only while the block is idle; the block
// does not enforce this. The seed register is used by the reseed command.
// Next, fraction, reseed and empty-range commands go from acceptance
// through the execute state to the done state that registers the result.
// A range draw runs the masked word through the bit-serial remainder unit,
// one dividend bit per cycle; the done state then registers its result.
// A new request is accepted while a finished result still waits in the
// output register; if the receiver holds rsp_stall, the next result waits
// in its last state until the register frees, and the held beat stays put.
// Synchronous reset loads the standard xorshift128 state words, clears the
// seed register and empties the output register.
module xorshift128_range_generator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic signed [31:0]  req_range_low,
   input  logic signed [31:0]  req_range_high,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_value,
   input  logic                csr_wr_en,
   input  logic signed [31:0]  csr_wr_data
);
   import xsr_pkg::*;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [WordW-1:0] low_ff, low_in;
   logic [WordW-1:0] span_ff, span_in;
   logic [WordW-1:0] mag_ff, mag_in;
   logic [WordW-1:0] seed_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WordW-1:0] rsp_value_ff, rsp_value_in;

   state_ctl_type    ctl;
   logic             div_start;
   logic             div_done;
   logic [WordW-1:0] div_rem;
   logic [WordW-1:0] word_w;

   xsr_state u_state (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .seed   (seed_ff),
      .word_w (word_w)
   );

   xsr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (word_w & MASK31),
      .divisor   (mag_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      low_in       = low_ff;
      span_in      = span_ff;
      mag_in       = mag_ff;
      ctl          = '0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = cmd_type'(req_command);
               low_in   = req_range_low;
               span_in  = req_range_high - req_range_low;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // A negative span is drawn against its magnitude.
            mag_in = span_ff[WordW-1] ? (WordW'(0) - span_ff) : span_ff;
            state_in = ST_DONE;
            unique case (cmd_ff)
               CMD_NEXT, CMD_FRAC: ctl.advance = 1'b1;
               CMD_RANGE: begin
                  if (span_ff != '0) begin
                     ctl.advance = 1'b1;
                     state_in    = ST_START;
                  end
               end
               CMD_RESEED: ctl.reseed = 1'b1;
               default: ctl = '0;
            endcase
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               unique case (cmd_ff)
                  CMD_NEXT:   rsp_value_in = word_w;
                  CMD_RANGE:  rsp_value_in = (span_ff == '0) ? '0 : (div_rem + low_ff);
                  CMD_FRAC:   rsp_value_in = word_w & MASK23;
                  CMD_RESEED: rsp_value_in = '0;
                  default:    rsp_value_in = '0;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      low_ff       <= low_in;
      span_ff      <= span_in;
      mag_ff       <= mag_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = $signed(rsp_value_ff);

endmodule
